@@ hw/rtl/prp_pkg.sv @@
// ----------------------------------------------------------------------------
// prp_pkg
// Shared constants, codes and types of the page replacement simulator.
// ----------------------------------------------------------------------------
package prp_pkg;

  // Geometry
  localparam int FRAMES      = 3;
  localparam int FRAME_SLOTS = 4;
  localparam int MAX_REFS    = 32;
  localparam int STORE_DEPTH = 32;

  // Widths
  localparam int ADDR_W  = $clog2(STORE_DEPTH);
  localparam int CNT_W   = 6;
  localparam int PAGE_W  = 8;
  localparam int FRAME_W = 9;
  localparam int POL_W   = 2;
  localparam int OP_W    = 2;
  localparam int DIST_W  = 7;
  localparam int FIDX_W  = $clog2(FRAME_SLOTS);
  localparam int FILL_W  = $clog2(FRAME_SLOTS + 1);

  // Distance marker for a page that is never referenced again
  localparam logic [DIST_W-1:0]  NEVER_AGAIN = 7'd100;
  // Empty frame marker (-1)
  localparam logic [FRAME_W-1:0] EMPTY_FRAME = 9'h1FF;

  // Command codes
  localparam logic [OP_W-1:0] OP_APPEND = 2'd0;
  localparam logic [OP_W-1:0] OP_RUN    = 2'd1;
  localparam logic [OP_W-1:0] OP_CLEAR  = 2'd2;

  // Replacement policy codes
  localparam logic [POL_W-1:0] POL_FIFO = 2'd0;
  localparam logic [POL_W-1:0] POL_LRU  = 2'd1;
  localparam logic [POL_W-1:0] POL_OPT  = 2'd2;

  typedef logic signed [FRAME_W-1:0] frame_t;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_LOOK,
    ST_SCAN,
    ST_EMIT
  } state_t;

endpackage

@@ hw/rtl/prp_req_if.sv @@
// ----------------------------------------------------------------------------
// prp_req_if
// Command channel: op code and page number with valid/ready.
// ----------------------------------------------------------------------------
interface prp_req_if import prp_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   op;
  logic [PAGE_W-1:0] page;

  modport source (output valid, output op, output page, input ready);
  modport sink   (input valid, input op, input page, output ready);
endinterface

@@ hw/rtl/prp_rsp_if.sv @@
// ----------------------------------------------------------------------------
// prp_rsp_if
// Result channel: one replay step (page, hit, frames, fault count, last).
// ----------------------------------------------------------------------------
interface prp_rsp_if import prp_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [PAGE_W-1:0] ref_page;
  logic              hit;
  frame_t            frame_0;
  frame_t            frame_1;
  frame_t            frame_2;
  frame_t            frame_3;
  logic [CNT_W-1:0]  fault_total;
  logic              last;

  modport source (output valid, output ref_page, output hit, output frame_0,
                  output frame_1, output frame_2, output frame_3,
                  output fault_total, output last, input ready);
  modport sink   (input valid, input ref_page, input hit, input frame_0,
                  input frame_1, input frame_2, input frame_3,
                  input fault_total, input last, output ready);
endinterface

@@ hw/rtl/prp_cfg_if.sv @@
// ----------------------------------------------------------------------------
// prp_cfg_if
// Configuration write channel for the policy register.
// ----------------------------------------------------------------------------
interface prp_cfg_if import prp_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [POL_W-1:0] data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

@@ hw/rtl/page_replacement_simulator_core.sv @@
// A run command moves the sequencer from idle through the read and look states
// to emit, and each result is registered; append and clear transfer in idle.
// Each replayed reference passes through read, look and emit, and the emit state
// waits while an earlier result is not yet taken. An optimal eviction adds a scan
// of the remaining references, one store read per cycle on the single read port.
// Reset: synchronous, clears reference count, policy (FIFO) and output valid.
// ----------------------------------------------------------------------------
// page_replacement_simulator_core
// Stores page references in a synchronous RAM and replays them under a
// FIFO, LRU or optimal replacement policy, one result per reference.
// ----------------------------------------------------------------------------
module page_replacement_simulator_core import prp_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  prp_req_if.sink    req,
  prp_rsp_if.source  rsp,
  prp_cfg_if.sink    cfg
);

  // Control state
  state_t            state, state_next;
  logic [POL_W-1:0]  policy;
  logic [CNT_W-1:0]  ref_count;
  logic [CNT_W-1:0]  idx;
  logic [CNT_W-1:0]  scan_pos;
  logic [CNT_W-1:0]  pend_pos;
  logic              scan_pend;
  logic [FILL_W-1:0] filled;
  logic [CNT_W-1:0]  fault_cnt;

  // Step datapath
  frame_t            frames [FRAME_SLOTS];
  frame_t            frames_next [FRAME_SLOTS];
  logic [DIST_W-1:0] next_use [FRAMES];
  logic [PAGE_W-1:0] cur;
  logic              hit_q;
  logic [FIDX_W-1:0] slot_q;

  // Reference store
  logic [PAGE_W-1:0] store [STORE_DEPTH];
  logic [PAGE_W-1:0] rd_data;
  logic              rd_en;
  logic [ADDR_W-1:0] rd_addr;
  logic              wr_en;

  // Strobes
  logic              req_ready;
  logic              req_xfer;
  logic              run_start;
  logic              scan_issue;
  logic              emit_go;
  logic              last_ref;

  // Output register
  logic              out_valid;
  logic [PAGE_W-1:0] out_page;
  logic              out_hit;
  frame_t            out_frame [FRAME_SLOTS];
  logic [CNT_W-1:0]  out_faults;
  logic              out_last;

  // Residency and eviction choice
  logic              match_any;
  logic [FIDX_W-1:0] match_slot;
  logic [FIDX_W-1:0] victim;
  logic [DIST_W-1:0] best;
  logic [FIDX_W-1:0] upto;
  logic              shift_en;
  logic              need_scan;

  assign req_xfer  = req.valid && req_ready;
  assign run_start = req_xfer && (req.op == OP_RUN) && (ref_count != '0);
  assign wr_en     = req_xfer && (req.op == OP_APPEND) &&
                     (ref_count < CNT_W'(MAX_REFS));
  assign last_ref  = ((idx + 1'b1) == ref_count);

  // Lookup of the fetched page in the frame list, lowest slot wins
  always_comb begin
    match_any  = 1'b0;
    match_slot = '0;
    for (int j = FRAMES - 1; j >= 0; j--) begin
      if (frames[j] == {1'b0, rd_data}) begin
        match_any  = 1'b1;
        match_slot = FIDX_W'(j);
      end
    end
  end

  assign need_scan = (policy == POL_OPT) && !match_any &&
                     (filled == FILL_W'(FRAMES));

  // Victim: furthest next use, ties to the lowest index
  always_comb begin
    best   = '0;
    victim = '0;
    for (int j = FRAMES - 1; j >= 0; j--) begin
      if (next_use[j] >= best) begin
        best   = next_use[j];
        victim = FIDX_W'(j);
      end
    end
  end

  // Shift depth of the frame list for this step
  always_comb begin
    case (policy)
      POL_LRU: begin
        upto     = hit_q ? slot_q : FIDX_W'(FRAMES - 1);
        shift_en = 1'b1;
      end
      POL_OPT: begin
        upto     = (filled < FILL_W'(FRAMES)) ? FIDX_W'(filled) : victim;
        shift_en = !hit_q;
      end
      default: begin
        upto     = FIDX_W'(FRAMES - 1);
        shift_en = !hit_q;
      end
    endcase
  end

  // Frame list after push to front
  always_comb begin
    for (int j = 0; j < FRAME_SLOTS; j++) begin
      frames_next[j] = frames[j];
    end
    if (shift_en) begin
      frames_next[0] = frame_t'({1'b0, cur});
      for (int j = 1; j < FRAME_SLOTS; j++) begin
        if (FIDX_W'(j) <= upto) begin
          frames_next[j] = frames[j-1];
        end
      end
    end
  end

  // Sequencer: next state and strobes
  always_comb begin
    state_next = state;
    req_ready  = 1'b0;
    rd_en      = 1'b0;
    rd_addr    = idx[ADDR_W-1:0];
    scan_issue = 1'b0;
    emit_go    = 1'b0;
    case (state)
      ST_IDLE: begin
        req_ready = 1'b1;
        if (run_start) begin
          state_next = ST_READ;
        end
      end
      ST_READ: begin
        rd_en      = 1'b1;
        state_next = ST_LOOK;
      end
      ST_LOOK: begin
        state_next = need_scan ? ST_SCAN : ST_EMIT;
      end
      ST_SCAN: begin
        if (scan_pos < ref_count) begin
          rd_en      = 1'b1;
          rd_addr    = scan_pos[ADDR_W-1:0];
          scan_issue = 1'b1;
        end else if (!scan_pend) begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (!out_valid || rsp.ready) begin
          emit_go    = 1'b1;
          state_next = last_ref ? ST_IDLE : ST_READ;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      policy    <= POL_FIFO;
      ref_count <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg.valid) begin
        policy <= cfg.data;
      end
      if (wr_en) begin
        ref_count <= ref_count + 1'b1;
      end else if (req_xfer && (req.op == OP_CLEAR)) begin
        ref_count <= '0;
      end
      if (emit_go) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Reference store, one write or one read per cycle
  always_ff @(posedge clk) begin
    if (wr_en) begin
      store[ref_count[ADDR_W-1:0]] <= req.page;
    end
    if (rd_en) begin
      rd_data <= store[rd_addr];
    end
  end

  // Step datapath
  always_ff @(posedge clk) begin
    if (run_start) begin
      for (int j = 0; j < FRAME_SLOTS; j++) begin
        frames[j] <= frame_t'(EMPTY_FRAME);
      end
      fault_cnt <= '0;
      idx       <= '0;
      filled    <= '0;
    end
    // Capture the reference and prepare the lookahead
    if (state == ST_LOOK) begin
      cur       <= rd_data;
      hit_q     <= match_any;
      slot_q    <= match_slot;
      scan_pos  <= idx + 1'b1;
      scan_pend <= 1'b0;
      for (int j = 0; j < FRAMES; j++) begin
        next_use[j] <= NEVER_AGAIN;
      end
    end
    // Lookahead: first future use of each frame
    if (state == ST_SCAN) begin
      scan_pend <= scan_issue;
      pend_pos  <= scan_pos;
      if (scan_issue) begin
        scan_pos <= scan_pos + 1'b1;
      end
      if (scan_pend) begin
        for (int j = 0; j < FRAMES; j++) begin
          if ((next_use[j] == NEVER_AGAIN) && (frames[j] == {1'b0, rd_data})) begin
            next_use[j] <= DIST_W'(pend_pos - idx);
          end
        end
      end
    end
    // Commit step and load the result
    if (emit_go) begin
      for (int j = 0; j < FRAME_SLOTS; j++) begin
        frames[j]    <= frames_next[j];
        out_frame[j] <= (j < FRAMES) ? frames_next[j] : frame_t'(EMPTY_FRAME);
      end
      if (!hit_q) begin
        fault_cnt <= fault_cnt + 1'b1;
      end
      if ((policy == POL_OPT) && !hit_q && (filled < FILL_W'(FRAMES))) begin
        filled <= filled + 1'b1;
      end
      idx        <= idx + 1'b1;
      out_page   <= cur;
      out_hit    <= hit_q;
      out_faults <= hit_q ? fault_cnt : fault_cnt + 1'b1;
      out_last   <= last_ref;
    end
  end

  // Ports
  assign req.ready       = req_ready;
  assign cfg.ready       = 1'b1;
  assign rsp.valid       = out_valid;
  assign rsp.ref_page    = out_page;
  assign rsp.hit         = out_hit;
  assign rsp.frame_0     = out_frame[0];
  assign rsp.frame_1     = out_frame[1];
  assign rsp.frame_2     = out_frame[2];
  assign rsp.frame_3     = out_frame[3];
  assign rsp.fault_total = out_faults;
  assign rsp.last        = out_last;

endmodule

@@ hw/rtl/prp_checker.sv @@
// ----------------------------------------------------------------------------
// prp_checker
// Port-level assertions for the page replacement simulator core.
// ----------------------------------------------------------------------------
module prp_checker import prp_pkg::*; (
  input logic               clk,
  input logic               rst,
  input logic               req_ready,
  input logic               rsp_valid,
  input logic               rsp_ready,
  input logic [PAGE_W-1:0]  rsp_ref_page,
  input logic               rsp_hit,
  input logic [FRAME_W-1:0] rsp_frame_0,
  input logic [FRAME_W-1:0] rsp_frame_1,
  input logic [FRAME_W-1:0] rsp_frame_2,
  input logic [FRAME_W-1:0] rsp_frame_3,
  input logic [CNT_W-1:0]   rsp_fault_total,
  input logic               rsp_last
);

  // No result survives reset
  a_rst_clears: assert property (@(posedge clk) rst |=> !rsp_valid)
    else $error("result valid after reset");

  // Stalled result holds: page, hit, first frame, fault total and last
  a_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_ref_page) &&
      $stable(rsp_hit) && $stable(rsp_frame_0) && $stable(rsp_fault_total) &&
      $stable(rsp_last))
    else $error("stalled result changed");

  // A run in progress takes no command
  a_busy: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_last |-> !req_ready)
    else $error("command taken during a run");

  // A hit page is resident
  a_hit_resident: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_hit |->
      (rsp_frame_0 == {1'b0, rsp_ref_page}) || (rsp_frame_1 == {1'b0, rsp_ref_page}) ||
      (rsp_frame_2 == {1'b0, rsp_ref_page}) || (rsp_frame_3 == {1'b0, rsp_ref_page}))
    else $error("hit page not in frames");

  // A faulting page enters at the front and is counted
  a_miss_front: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_hit |-> (rsp_frame_0 == {1'b0, rsp_ref_page}) &&
      (rsp_fault_total != '0))
    else $error("faulting page not at front");

endmodule

bind page_replacement_simulator_core prp_checker u_prp_checker (
  .clk             (clk),
  .rst             (rst),
  .req_ready       (req.ready),
  .rsp_valid       (rsp.valid),
  .rsp_ready       (rsp.ready),
  .rsp_ref_page    (rsp.ref_page),
  .rsp_hit         (rsp.hit),
  .rsp_frame_0     (rsp.frame_0),
  .rsp_frame_1     (rsp.frame_1),
  .rsp_frame_2     (rsp.frame_2),
  .rsp_frame_3     (rsp.frame_3),
  .rsp_fault_total (rsp.fault_total),
  .rsp_last        (rsp.last)
);

@@ tb/tb_page_replacement_simulator_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_page_replacement_simulator_core
// Self-checking bench for the page replacement core. A driver fed from a
// queue of commands loads and replays page reference strings under every
// policy. A shadow model predicts each replay step. A monitor compares every
// result transfer with the oldest predicted step. Both handshakes see random
// gaps and stalls.
// ----------------------------------------------------------------------------
module tb_page_replacement_simulator_core;
  import prp_pkg::*;

  // Codes that the package leaves unnamed
  localparam logic [OP_W-1:0]  OP_SPARE  = 2'd3;
  localparam logic [POL_W-1:0] POL_SPARE = 2'd3;

  localparam int ITEMS_TARGET   = 270;
  localparam int SETTLE_CYCLES  = 16;
  localparam int TAIL_CYCLES    = 24;
  localparam int WATCHDOG_LIMIT = 4000;

  typedef enum {JOB_REQ, JOB_CFG, JOB_HOLD} job_kind_t;

  typedef struct {
    job_kind_t          kind;
    logic [OP_W-1:0]    op;
    logic [PAGE_W-1:0]  page;
    logic [POL_W-1:0]   pol;
  } job_t;

  typedef struct {
    logic [PAGE_W-1:0]  ref_page;
    logic               hit;
    frame_t             frames [FRAME_SLOTS];
    logic [CNT_W-1:0]   fault_total;
    logic               last;
  } step_t;

  logic clk;
  logic rst;

  prp_req_if req_ch ();
  prp_rsp_if rsp_ch ();
  prp_cfg_if cfg_ch ();

  page_replacement_simulator_core uut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch),
    .cfg (cfg_ch)
  );

  // Command queue and predicted replay steps
  job_t  cmd_queue [$];
  step_t pending_steps [$];

  // Shadow state of the core
  logic [PAGE_W-1:0] page_log [STORE_DEPTH];
  int                log_len;
  frame_t            frame_now [FRAME_SLOTS];
  logic [CNT_W-1:0]  faults;
  logic [POL_W-1:0]  policy_shadow;

  // Bookkeeping
  int jobs_total;
  int jobs_done;
  int req_items;
  int error_count;
  int steps_checked;
  int runs_issued;
  int cfg_writes;
  int quiet_cycles;
  int gap_left;
  int stall_left;
  int send_burst;
  int recv_burst;
  int idle_cycles;
  bit [3:0] policies_run;

  // Clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Reset and known input levels from time zero
  initial begin
    rst          = 1'b1;
    req_ch.valid = 1'b0;
    req_ch.op    = OP_APPEND;
    req_ch.page  = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.data  = POL_FIFO;
    rsp_ch.ready = 1'b0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
  end

  task automatic flag_error(string msg);
    $display("ERROR: %s", msg);
    error_count++;
  endtask

  // Gap length: mostly short, a few long, and bursts with none at all
  function automatic int pick_pause(inout int burst_left);
    int roll;
    if (burst_left > 0) begin
      burst_left--;
      return 0;
    end
    roll = $urandom_range(0, 99);
    if (roll < 5) begin
      burst_left = $urandom_range(10, 40);
      return 0;
    end
    if (roll < 55) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Insert a page at the front, shifting frames [0 .. upto-1] back one place
  function automatic void shift_in(int upto, frame_t pg);
    if (upto >= FRAME_SLOTS) upto = FRAME_SLOTS - 1;
    for (int j = upto; j > 0; j--) frame_now[j] = frame_now[j-1];
    frame_now[0] = pg;
  endfunction

  // Shadow model: apply one accepted command, queue the steps it produces
  task automatic apply_command(logic [OP_W-1:0] op, logic [PAGE_W-1:0] pg);
    int     slot;
    int     filled;
    int     victim;
    int     best;
    int     reuse_dist;
    frame_t cur;
    step_t  step;
    case (op)
      OP_APPEND: begin
        if (log_len < MAX_REFS) begin
          page_log[log_len] = pg;
          log_len++;
        end
      end
      OP_CLEAR: log_len = 0;
      OP_RUN: begin
        runs_issued++;
        policies_run[policy_shadow] = 1'b1;
        for (int j = 0; j < FRAME_SLOTS; j++) frame_now[j] = EMPTY_FRAME;
        faults = '0;
        filled = 0;
        for (int i = 0; i < log_len; i++) begin
          cur  = frame_t'({1'b0, page_log[i]});
          slot = -1;
          for (int j = FRAMES - 1; j >= 0; j--) if (frame_now[j] == cur) slot = j;
          if (policy_shadow == POL_LRU) begin
            shift_in((slot >= 0) ? slot : FRAMES - 1, cur);
          end else if (policy_shadow == POL_OPT) begin
            if (slot < 0) begin
              if (filled < FRAMES) begin
                filled++;
                shift_in(filled - 1, cur);
              end else begin
                // victim: next use furthest ahead, ties to the lowest index
                victim = 0;
                best   = 0;
                for (int j = FRAMES - 1; j >= 0; j--) begin
                  reuse_dist = NEVER_AGAIN;
                  for (int k = i + 1; k < log_len; k++) begin
                    if (frame_t'({1'b0, page_log[k]}) == frame_now[j]) begin
                      reuse_dist = k - i;
                      break;
                    end
                  end
                  if (reuse_dist >= best) begin
                    best   = reuse_dist;
                    victim = j;
                  end
                end
                shift_in(victim, cur);
              end
            end
          end else if (slot < 0) begin
            // FIFO, and the spare policy code
            shift_in(FRAMES - 1, cur);
          end
          if (slot < 0) faults++;
          step.ref_page = page_log[i];
          step.hit      = (slot >= 0);
          for (int j = 0; j < FRAME_SLOTS; j++)
            step.frames[j] = (j < FRAMES) ? frame_now[j] : EMPTY_FRAME;
          step.fault_total = faults;
          step.last        = (i == log_len - 1);
          pending_steps.push_back(step);
        end
      end
      default: ;
    endcase
  endtask

  // Stimulus queue helpers
  task automatic push_req(logic [OP_W-1:0] op, logic [PAGE_W-1:0] pg);
    job_t j;
    j.kind = JOB_REQ;
    j.op   = op;
    j.page = pg;
    j.pol  = POL_FIFO;
    cmd_queue.push_back(j);
    jobs_total++;
    req_items++;
  endtask

  task automatic push_cfg(logic [POL_W-1:0] pol);
    job_t j;
    j.kind = JOB_CFG;
    j.op   = OP_APPEND;
    j.page = '0;
    j.pol  = pol;
    cmd_queue.push_back(j);
    jobs_total++;
  endtask

  task automatic push_hold();
    job_t j;
    j.kind = JOB_HOLD;
    j.op   = OP_APPEND;
    j.page = '0;
    j.pol  = POL_FIFO;
    cmd_queue.push_back(j);
    jobs_total++;
  endtask

  // One random phase: mostly clear / load / replay, some noise and broken loads
  task automatic add_sequence();
    logic [PAGE_W-1:0] pool [6];
    int npool;
    int len;
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 12) begin
      repeat ($urandom_range(1, 4))
        push_req(OP_W'($urandom_range(0, 3)), PAGE_W'($urandom_range(0, 255)));
    end else begin
      // clear first, or (broken load) keep appending to whatever is stored; may overflow
      if (roll >= 22) push_req(OP_CLEAR, PAGE_W'($urandom_range(0, 255)));
      npool = $urandom_range(2, 6);
      for (int i = 0; i < 6; i++) pool[i] = PAGE_W'($urandom_range(0, 255));
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(28, 34) : $urandom_range(1, 12);
      repeat (len) push_req(OP_APPEND, pool[$urandom_range(0, npool - 1)]);
      push_req(OP_RUN, PAGE_W'($urandom_range(0, 255)));
      if ($urandom_range(0, 3) == 0) begin
        push_cfg(POL_W'($urandom_range(0, 3)));
        push_req(OP_RUN, PAGE_W'($urandom_range(0, 255)));
      end
    end
  endtask

  task automatic build_stimulus();
    // Directed: empty run, spare op, a short string under every policy
    push_req(OP_RUN, 8'h00);
    push_req(OP_SPARE, 8'hA5);
    push_req(OP_APPEND, 8'h00);
    push_req(OP_APPEND, 8'hFF);
    push_req(OP_APPEND, 8'h07);
    push_req(OP_APPEND, 8'h00);
    push_req(OP_APPEND, 8'h09);
    push_req(OP_APPEND, 8'hFF);
    push_req(OP_RUN, 8'hFF);
    push_cfg(POL_LRU);
    push_req(OP_RUN, 8'h00);
    push_cfg(POL_OPT);
    push_req(OP_RUN, 8'h00);
    push_cfg(POL_SPARE);
    push_req(OP_RUN, 8'h00);
    push_hold();
    push_req(OP_CLEAR, 8'hFF);
    push_req(OP_RUN, 8'h00);
    push_req(OP_APPEND, 8'h80);
    push_req(OP_APPEND, 8'h01);
    push_req(OP_APPEND, 8'h80);
    push_req(OP_RUN, 8'h00);
    push_cfg(POL_FIFO);
    // Random phases
    push_hold();
    while (req_items < ITEMS_TARGET) begin
      if ($urandom_range(0, 2) == 0) push_cfg(POL_W'($urandom_range(0, 3)));
      add_sequence();
    end
  endtask

  // Driver: commands and register writes, one transfer at a time
  always @(posedge clk) begin
    if (rst) begin
      req_ch.valid <= 1'b0;
      cfg_ch.valid <= 1'b0;
      quiet_cycles = 0;
      gap_left     = 0;
    end else begin
      if (req_ch.valid && req_ch.ready) begin
        apply_command(req_ch.op, req_ch.page);
        jobs_done++;
        gap_left = pick_pause(send_burst);
      end
      if (cfg_ch.valid && cfg_ch.ready) begin
        policy_shadow = cfg_ch.data;
        jobs_done++;
        cfg_writes++;
      end
      // cycles with nothing in flight, before a write or a hold completes
      if (pending_steps.size() != 0 || req_ch.valid || cfg_ch.valid) quiet_cycles = 0;
      else quiet_cycles++;

      if ((req_ch.valid && !req_ch.ready) || (cfg_ch.valid && !cfg_ch.ready)) begin
        // transfer pending, hold everything
      end else if (gap_left > 0) begin
        gap_left--;
        req_ch.valid <= 1'b0;
        cfg_ch.valid <= 1'b0;
      end else if (cmd_queue.size() == 0) begin
        req_ch.valid <= 1'b0;
        cfg_ch.valid <= 1'b0;
      end else if (cmd_queue[0].kind == JOB_REQ) begin
        req_ch.valid <= 1'b1;
        req_ch.op    <= cmd_queue[0].op;
        req_ch.page  <= cmd_queue[0].page;
        cfg_ch.valid <= 1'b0;
        void'(cmd_queue.pop_front());
      end else if (quiet_cycles < SETTLE_CYCLES) begin
        req_ch.valid <= 1'b0;
        cfg_ch.valid <= 1'b0;
      end else if (cmd_queue[0].kind == JOB_CFG) begin
        cfg_ch.valid <= 1'b1;
        cfg_ch.data  <= cmd_queue[0].pol;
        req_ch.valid <= 1'b0;
        void'(cmd_queue.pop_front());
      end else begin
        // hold point reached: block drained
        void'(cmd_queue.pop_front());
        jobs_done++;
        req_ch.valid <= 1'b0;
        cfg_ch.valid <= 1'b0;
      end
    end
  end

  // Monitor: random ready, compare each result transfer with the oldest step
  always @(posedge clk) begin
    step_t  want;
    frame_t got [FRAME_SLOTS];
    if (rst) begin
      rsp_ch.ready <= 1'b0;
      stall_left = 0;
    end else begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        if (pending_steps.size() == 0) begin
          flag_error($sformatf("result with no step pending, ref_page %0d", rsp_ch.ref_page));
        end else begin
          want = pending_steps.pop_front();
          got  = '{rsp_ch.frame_0, rsp_ch.frame_1, rsp_ch.frame_2, rsp_ch.frame_3};
          if (rsp_ch.ref_page !== want.ref_page)
            flag_error($sformatf("step %0d ref_page: got %0d expected %0d",
                                 steps_checked, rsp_ch.ref_page, want.ref_page));
          if (rsp_ch.hit !== want.hit)
            flag_error($sformatf("step %0d hit: got %0b expected %0b",
                                 steps_checked, rsp_ch.hit, want.hit));
          for (int j = 0; j < FRAME_SLOTS; j++)
            if (got[j] !== want.frames[j])
              flag_error($sformatf("step %0d frame_%0d: got %0d expected %0d",
                                   steps_checked, j, got[j], want.frames[j]));
          if (rsp_ch.fault_total !== want.fault_total)
            flag_error($sformatf("step %0d fault_total: got %0d expected %0d",
                                 steps_checked, rsp_ch.fault_total, want.fault_total));
          if (rsp_ch.last !== want.last)
            flag_error($sformatf("step %0d last: got %0b expected %0b",
                                 steps_checked, rsp_ch.last, want.last));
        end
        steps_checked++;
      end
      if (stall_left > 0) begin
        stall_left--;
        rsp_ch.ready <= 1'b0;
      end else begin
        rsp_ch.ready <= 1'b1;
        stall_left = pick_pause(recv_burst);
      end
    end
  end

  // Watchdog: too long without any transfer
  always @(posedge clk) begin
    if (rst) begin
      idle_cycles = 0;
    end else begin
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
          (cfg_ch.valid && cfg_ch.ready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("timeout after %0d cycles without a transfer", idle_cycles);
        $display("page_replacement_simulator_core test failed");
        $finish;
      end
    end
  end

  // Sequencing of the run and final verdict
  initial begin
    log_len       = 0;
    faults        = '0;
    policy_shadow = POL_FIFO;
    for (int j = 0; j < FRAME_SLOTS; j++) frame_now[j] = EMPTY_FRAME;
    build_stimulus();
    @(posedge clk);
    while (rst) @(posedge clk);
    while (jobs_done < jobs_total || pending_steps.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    $display("%0d commands, %0d replays, %0d policy writes, %0d steps checked",
             req_items, runs_issued, cfg_writes, steps_checked);
    $display("policies replayed (bit per code): %b, mismatches: %0d",
             policies_run, error_count);
    if (error_count == 0) begin
      $display("page_replacement_simulator_core test passed");
    end else begin
      $display("page_replacement_simulator_core test failed");
    end
    $finish;
  end

endmodule
